// ===== design/swmf_pkg.sv =====
// ----------------------------------------------------------------------------
// swmf_pkg: shared types and constants of the running median filter
// Sample width, window default, and the record that a sorted cell shows to
// its neighbors.
// ----------------------------------------------------------------------------
package swmf_pkg;

  localparam int DATA_W     = 16;
  localparam int WINDOW_DEF = 5;
  localparam int WINDOW_MAX = 15;
  localparam int AGE_W      = $clog2(WINDOW_MAX);

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [AGE_W-1:0]  age_t;

  typedef struct packed {
    data_t val;
    age_t  age;
    logic  le;
    logic  keep;
  } tap_t;

endpackage

// ===== design/swmf_sample_if.sv =====
// ----------------------------------------------------------------------------
// swmf_sample_if: sample channel
// Valid/ready channel that carries one distance sample per transaction.
// ----------------------------------------------------------------------------
interface swmf_sample_if;
  logic            valid;
  logic            ready;
  swmf_pkg::data_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== design/swmf_median_if.sv =====
// ----------------------------------------------------------------------------
// swmf_median_if: median channel
// Valid/ready channel that carries one window median per transaction.
// ----------------------------------------------------------------------------
interface swmf_median_if;
  logic            valid;
  logic            ready;
  swmf_pkg::data_t median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

// ===== design/sliding_window_median_filter.sv =====
// ----------------------------------------------------------------------------
// sliding_window_median_filter: running median over a sliding window
// Keeps the last WINDOW samples as a sorted row of cells tagged with ages;
// each sample replaces the oldest entry and the middle cell gives the median.
//
//   channel   dir   payload          transaction
//   samples   in    sample[15:0]     valid & ready
//   medians   out   median[15:0]     valid & ready
//
// One sample per cycle unless the output stalls; the median is registered on
// acceptance. The sorted cell row updates per sample and sets the rate.
// Reset clears every entry to zero and the output register to empty.
// A stalled median holds in the output register; samples are still taken
// in the cycle that the held median is consumed.
// ----------------------------------------------------------------------------
module sliding_window_median_filter #(
  parameter int WINDOW = swmf_pkg::WINDOW_DEF
) (
  input logic         clk,
  input logic         rst,
  swmf_sample_if.sink samples,
  swmf_median_if.source medians
);

  localparam int MID = WINDOW / 2;

  localparam swmf_pkg::tap_t LEFT_EDGE  = '{val: '0, age: '0, le: 1'b1, keep: 1'b1};
  localparam swmf_pkg::tap_t RIGHT_EDGE = '{val: '0, age: '0, le: 1'b0, keep: 1'b0};

  swmf_pkg::tap_t  taps     [WINDOW];
  swmf_pkg::data_t val_nexts[WINDOW];
  logic            en;
  logic            out_valid;
  swmf_pkg::data_t median;

  assign samples.ready = ~out_valid | medians.ready;
  assign en            = samples.valid & samples.ready;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    swmf_pkg::tap_t left_tap;
    swmf_pkg::tap_t right_tap;

    if (i == 0) begin : g_first
      assign left_tap = LEFT_EDGE;
    end else begin : g_inner_l
      assign left_tap = taps[i-1];
    end

    if (i == WINDOW - 1) begin : g_last
      assign right_tap = RIGHT_EDGE;
    end else begin : g_inner_r
      assign right_tap = taps[i+1];
    end

    swmf_cell #(
      .WINDOW   (WINDOW),
      .INIT_AGE (WINDOW - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .x        (samples.sample),
      .left     (left_tap),
      .right    (right_tap),
      .tap      (taps[i]),
      .val_next (val_nexts[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= 1'b1;
    end else if (medians.ready) begin
      out_valid <= 1'b0;
    end
    if (en) begin
      median <= val_nexts[MID];
    end
  end

  assign medians.valid  = out_valid;
  assign medians.median = median;

`ifndef SYNTHESIS
  logic [WINDOW-1:0] old_vec;
  logic [WINDOW-1:0] order_ok;

  for (genvar j = 0; j < WINDOW; j++) begin : g_chk
    assign old_vec[j] = (taps[j].age == swmf_pkg::AGE_W'(WINDOW - 1));
    if (j == 0) begin : g_c0
      assign order_ok[j] = 1'b1;
    end else begin : g_cn
      assign order_ok[j] = (taps[j-1].val <= taps[j].val);
    end
  end

  a_one_oldest: assert property (@(posedge clk) disable iff (rst) $onehot(old_vec))
    else $error("window must hold exactly one oldest entry");

  a_sorted: assert property (@(posedge clk) disable iff (rst) &order_ok)
    else $error("cell row lost ascending order");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
      en |=> (medians.valid && medians.median == $past(val_nexts[MID])))
    else $error("accepted sample did not produce a median");
`endif

endmodule

// ===== design/swmf_cell.sv =====
// ----------------------------------------------------------------------------
// swmf_cell: one position of the sorted window
// Holds one window entry and its age. On each transaction the entry with the
// highest age leaves and the new sample enters; every cell takes its new
// content from itself, a neighbor, or the sample, keeping the row sorted.
// ----------------------------------------------------------------------------
module swmf_cell #(
  parameter int WINDOW   = swmf_pkg::WINDOW_DEF,
  parameter int INIT_AGE = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  swmf_pkg::data_t  x,
  input  swmf_pkg::tap_t   left,
  input  swmf_pkg::tap_t   right,
  output swmf_pkg::tap_t   tap,
  output swmf_pkg::data_t  val_next
);

  swmf_pkg::data_t val;
  swmf_pkg::age_t  age;
  swmf_pkg::age_t  age_next;

  logic            old;
  logic            le_own;
  logic            keep_own;
  logic            r_le;
  logic            l_le;
  swmf_pkg::data_t r_val;
  swmf_pkg::data_t l_val;
  swmf_pkg::age_t  r_age;
  swmf_pkg::age_t  l_age;

  always_comb begin
    old      = (age == swmf_pkg::AGE_W'(WINDOW - 1));
    le_own   = (val <= x);
    keep_own = left.keep & ~old;

    r_val = keep_own ? val    : right.val;
    r_age = keep_own ? age    : right.age;
    r_le  = keep_own ? le_own : right.le;
    l_val = left.keep ? left.val : val;
    l_age = left.keep ? left.age : age;
    l_le  = left.keep ? left.le  : le_own;

    if (r_le) begin
      val_next = r_val;
      age_next = r_age + swmf_pkg::AGE_W'(1);
    end else if (!l_le) begin
      val_next = l_val;
      age_next = l_age + swmf_pkg::AGE_W'(1);
    end else begin
      val_next = x;
      age_next = '0;
    end

    tap.val  = val;
    tap.age  = age;
    tap.le   = le_own;
    tap.keep = keep_own;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val <= '0;
      age <= swmf_pkg::AGE_W'(INIT_AGE);
    end else if (en) begin
      val <= val_next;
      age <= age_next;
    end
  end

endmodule

// ===== dv/sliding_window_median_filter_tb.sv =====
// ----------------------------------------------------------------------------
// sliding_window_median_filter_tb: self-checking bench for the running median
// Streams distance samples through the filter with random idle cycles on both
// channels and checks every median against a window kept in the bench.
// ----------------------------------------------------------------------------
module sliding_window_median_filter_tb;

  localparam int WIN       = swmf_pkg::WINDOW_DEF;
  localparam int LONG_HOLD = 60;
  localparam int DRAIN_CYC = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  swmf_sample_if sample_ch ();
  swmf_median_if median_ch ();

  sliding_window_median_filter #(.WINDOW(WIN)) uut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch.sink),
    .medians (median_ch.source)
  );

  swmf_pkg::data_t ring [WIN];
  int              ring_slot;
  swmf_pkg::data_t pending_medians [$];
  int              errors;

  bit tx_idle_on;
  bit rx_idle_on;
  int hold_ask;
  int hold_seen;
  int hold_left;
  int stall_left;

  always #5 clk = ~clk;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic swmf_pkg::data_t window_median();
    swmf_pkg::data_t sorted [WIN];
    swmf_pkg::data_t key;
    int              k;
    for (int i = 0; i < WIN; i++) sorted[i] = ring[i];
    for (int i = 1; i < WIN; i++) begin
      key = sorted[i];
      k   = i;
      while (k > 0 && sorted[k-1] > key) begin
        sorted[k] = sorted[k-1];
        k--;
      end
      sorted[k] = key;
    end
    return sorted[WIN/2];
  endfunction

  task automatic insert_sample(input swmf_pkg::data_t v);
    if (ring_slot >= WIN) ring_slot = 0;
    ring[ring_slot] = v;
    ring_slot = (ring_slot + 1 >= WIN) ? 0 : ring_slot + 1;
    pending_medians.push_back(window_median());
  endtask

  task automatic send_sample(input swmf_pkg::data_t v);
    int gap;
    gap = tx_idle_on ? rand_gap() : 0;
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= v;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    insert_sample(v);
  endtask

  // receiver: random stalls plus long holds on request
  initial begin
    median_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        median_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_left = LONG_HOLD - 1;
        median_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        median_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        median_ch.ready <= 1'b1;
        if (rx_idle_on) stall_left = rand_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && median_ch.valid && median_ch.ready) begin
      if (pending_medians.size() == 0) begin
        $error("median: unexpected transaction, actual %0d", median_ch.median);
        errors++;
      end else begin
        if (median_ch.median !== pending_medians[0]) begin
          $error("median: expected %0d, actual %0d", pending_medians[0], median_ch.median);
          errors++;
        end
        void'(pending_medians.pop_front());
      end
    end
  end

  task automatic test_startup_zeros();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (WIN) send_sample(16'hFFFF);
  endtask

  task automatic test_extremes();
    swmf_pkg::data_t vals [8] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF,
                                  16'h0001, 16'hFFFE, 16'hAAAA, 16'h5555};
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    foreach (vals[i]) send_sample(vals[i]);
  endtask

  task automatic test_equal_samples();
    repeat (WIN + 1) send_sample(16'd1234);
    send_sample(16'd1235);
    send_sample(16'd1233);
    send_sample(16'd1234);
  endtask

  task automatic test_back_pressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_ask <= hold_ask + 1;
    repeat (24) send_sample(swmf_pkg::data_t'($urandom()));
    hold_ask <= hold_ask + 1;
    tx_idle_on = 1'b1;
    repeat (12) send_sample(swmf_pkg::data_t'($urandom()));
  endtask

  task automatic test_random_stream(input int count);
    swmf_pkg::data_t base;
    swmf_pkg::data_t v;
    int              r;
    base = swmf_pkg::data_t'($urandom());
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        r = $urandom_range(0, 3);
        tx_idle_on = r[0];
        rx_idle_on = r[1];
        base = swmf_pkg::data_t'($urandom());
        if ($urandom_range(0, 3) == 0) hold_ask <= hold_ask + 1;
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
        v = swmf_pkg::data_t'($urandom());
      end else if (r < 75) begin
        v = base + swmf_pkg::data_t'($urandom_range(0, 3));
      end else if (r < 90) begin
        v = $urandom_range(0, 1) ? swmf_pkg::data_t'($urandom_range(0, 7))
                                 : swmf_pkg::data_t'(16'hFFFF - $urandom_range(0, 7));
      end else begin
        base = base + swmf_pkg::data_t'($urandom_range(1, 50));
        v = base;
      end
      send_sample(v);
    end
  endtask

  initial begin
    int waited;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    for (int i = 0; i < WIN; i++) ring[i] = '0;
    ring_slot  = 0;
    errors     = 0;
    hold_ask   = 0;
    hold_seen  = 0;
    hold_left  = 0;
    stall_left = 0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_startup_zeros();
    test_extremes();
    test_equal_samples();
    test_back_pressure();
    test_random_stream(1000);

    sample_ch.valid <= 1'b0;
    waited = 0;
    while (pending_medians.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0 && pending_medians.size() == 0) begin
      $display("sliding_window_median_filter_tb: PASS");
    end else begin
      if (pending_medians.size() != 0)
        $error("median: %0d expected transactions never arrived", pending_medians.size());
      $display("sliding_window_median_filter_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("sliding_window_median_filter_tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
design/swmf_pkg.sv
design/swmf_sample_if.sv
design/swmf_median_if.sv
design/swmf_cell.sv
design/sliding_window_median_filter.sv
dv/sliding_window_median_filter_tb.sv
